// ===== sv/aags_pkg.sv =====
// Shared types and constants for the per-channel automatic gain step block.
package aags_pkg;

  // Field and datapath widths.
  localparam int unsigned RATE_W   = 22;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned BVOL_W   = 17;
  localparam int unsigned BSMP_W   = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned AVG_W    = 18;
  localparam int unsigned CNT_W    = 26;
  localparam int unsigned TOT_W    = 27;
  localparam int unsigned P1_W     = 44;
  localparam int unsigned P2_W     = 33;
  localparam int unsigned NUM_W    = 45;
  localparam int unsigned QUO_W    = 28;
  localparam int unsigned PRE_W    = 28;
  localparam int unsigned RECIP_W  = 29;
  localparam int unsigned PROD_W   = 57;
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned SCL_W    = 25;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Fixed-point constants.
  localparam logic [GAIN_W-1:0] UNITY_GAIN   = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX     = 24'hFF_FFFF;
  localparam logic [AVG_W-1:0]  UNITY_AVG    = 18'd65536;
  localparam logic [AVG_W-1:0]  AVG_MAX      = 18'h3_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX    = 26'h3FF_FFFF;
  localparam logic [AVG_W-1:0]  TH_QUIET_HI  = 18'd655;
  localparam logic [AVG_W-1:0]  TH_QUIET_LO  = 18'd7;
  localparam logic [AVG_W-1:0]  TH_LOUD      = 18'd16384;
  localparam logic [AVG_W-1:0]  TH_HYST_DOWN = 18'd3277;
  localparam logic [AVG_W-1:0]  TH_HYST_UP   = 18'd13107;
  localparam logic [RATE_W-1:0] RATE_RESET   = 22'd48000;

  // ceil(2^32 / d): exact quotient for any numerator below 2^28.
  localparam logic [RECIP_W-1:0] RECIP_10 = 29'd429496730;
  localparam logic [RECIP_W-1:0] RECIP_11 = 29'd390451573;

  // Command codes and register addresses.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic [PADDR_W-1:0] ADDR_RATE = 3'd0;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [CNT_W-1:0]  count;
    logic [AVG_W-1:0]  volume;
  } aags_entry_t;

  localparam aags_entry_t ENTRY_RESET = '{gain: UNITY_GAIN, count: '0, volume: UNITY_AVG};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_EVAL,
    ST_SCALE,
    ST_DONE
  } aags_state_e;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_CLEAR,
    OP_BAD
  } aags_op_e;

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_UP,
    DIR_DOWN
  } aags_dir_e;

endpackage

// ===== sv/aags_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module aags_ram #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [WIDTH-1:0]        wdata_i,
  input  logic                    re_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/aags_div.sv =====
// Restoring divider, one quotient bit per cycle; the quotient must fit QUO_W bits.
module aags_div #(
  parameter int unsigned NUM_W = 45,
  parameter int unsigned DEN_W = 27,
  parameter int unsigned QUO_W = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(QUO_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  sh_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // The low numerator bits shift out at the top while quotient bits enter at the bottom.
  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // The high part of the numerator is below the divisor when the quotient fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num_i[NUM_W-1:QUO_W]);
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_q  <= {sh_q[QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== sv/audio_auto_gain_step_core.sv =====
// Top level of the per-channel automatic gain step block.
//
// An update request goes through these steps after acceptance: one state reads the
// channel entry, one multiplies, one sums the rounded numerator and starts the divider,
// the restoring divider forms its 28 quotient bits, one per cycle, and then signals done
// to give the sample-weighted average, then one state evaluates the rules, one applies
// the reciprocal multiply for the 1.1 scaling and one writes back and loads the result.
// The next request is accepted in the cycle after the result is loaded. Clear requests
// and requests for a channel at or above CHANNELS go from acceptance straight to the
// step that loads the result. While the result register is full and stalled, a
// finished request waits in its last step.
// One request is in flight at a time; the result sits in an output register, so the
// next request is taken while the last result still waits. Channel state lives in
// one RAM; per-channel valid flags make reset and clear take effect at once, with no
// clearing pass. The stream rate register is at byte address 0 of the register port.
module audio_auto_gain_step_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aags_pkg::PADDR_W-1:0]        paddr,
  input  logic [aags_pkg::PDATA_W-1:0]        pwdata,
  output logic [aags_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [aags_pkg::CHAN_W-1:0]         channel_i,
  input  logic [aags_pkg::BVOL_W-1:0]         block_volume_i,
  input  logic [aags_pkg::BSMP_W-1:0]         block_samples_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [aags_pkg::GAIN_W-1:0]         gain_o,
  output logic [aags_pkg::AVG_W-1:0]          average_volume_o,
  output logic                                window_evaluated_o,
  output logic                                gain_changed_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [aags_pkg::RATE_W-1:0] rate_q;
  logic                        cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr == aags_pkg::ADDR_RATE);
  assign pready = 1'b1;
  assign prdata = (paddr == aags_pkg::ADDR_RATE)
                  ? aags_pkg::PDATA_W'(rate_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= aags_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate_q <= pwdata[aags_pkg::RATE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  aags_pkg::aags_state_e state_q, state_d;
  aags_pkg::aags_op_e    op_q, op_d;
  logic                  in_acc;
  logic                  chan_ok;
  logic [AW+2:0]         chan_ext;
  logic [AW-1:0]         chan_addr;
  logic                  out_load;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [aags_pkg::QUO_W-1:0] div_quo;
  logic [CHANNELS-1:0]   vld_q;

  assign in_acc     = in_valid_i && (state_q == aags_pkg::ST_IDLE);
  assign in_stall_o = (state_q != aags_pkg::ST_IDLE);
  assign chan_ok    = 32'(channel_i) < CHANNELS;
  assign chan_ext   = (AW + 3)'(channel_i);
  assign chan_addr  = chan_ext[AW-1:0];
  assign out_load   = (state_q == aags_pkg::ST_DONE) && (!out_valid_o || !out_stall_i);
  assign div_start  = (state_q == aags_pkg::ST_SUM);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      aags_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!chan_ok) begin
            op_d    = aags_pkg::OP_BAD;
            state_d = aags_pkg::ST_DONE;
          end else if (command_i == aags_pkg::CMD_CLEAR) begin
            op_d    = aags_pkg::OP_CLEAR;
            state_d = aags_pkg::ST_DONE;
          end else begin
            op_d    = aags_pkg::OP_UPDATE;
            state_d = aags_pkg::ST_LOAD;
          end
        end
      end
      aags_pkg::ST_LOAD:  state_d = aags_pkg::ST_MUL;
      aags_pkg::ST_MUL:   state_d = aags_pkg::ST_SUM;
      aags_pkg::ST_SUM:   state_d = aags_pkg::ST_DIV;
      aags_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = aags_pkg::ST_EVAL;
        end
      end
      aags_pkg::ST_EVAL:  state_d = aags_pkg::ST_SCALE;
      aags_pkg::ST_SCALE: state_d = aags_pkg::ST_DONE;
      aags_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = aags_pkg::ST_IDLE;
        end
      end
      default: state_d = aags_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aags_pkg::ST_IDLE;
      op_q    <= aags_pkg::OP_BAD;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel state memory
  // ---------------------------------------------------------------------------
  logic [AW-1:0]             addr_q;
  logic                      ram_we;
  aags_pkg::aags_entry_t     ram_wdata;
  logic [$bits(aags_pkg::aags_entry_t)-1:0] ram_rdata;
  aags_pkg::aags_entry_t     entry_rd;

  assign ram_we = out_load && (op_q == aags_pkg::OP_UPDATE);

  aags_ram #(
    .WIDTH ($bits(aags_pkg::aags_entry_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (chan_addr),
    .rdata_o (ram_rdata)
  );

  // An entry that was never written since reset or a clear reads as the reset entry.
  assign entry_rd = vld_q[addr_q] ? aags_pkg::aags_entry_t'(ram_rdata)
                                  : aags_pkg::ENTRY_RESET;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (out_load) begin
      if (op_q == aags_pkg::OP_UPDATE) begin
        vld_q[addr_q] <= 1'b1;
      end else if (op_q == aags_pkg::OP_CLEAR) begin
        vld_q[addr_q] <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic [aags_pkg::BVOL_W-1:0]  vol_q;
  logic [aags_pkg::BSMP_W-1:0]  smp_q;
  logic [aags_pkg::AVG_W-1:0]   avg_q;
  logic [aags_pkg::CNT_W-1:0]   cnt_q;
  logic [aags_pkg::GAIN_W-1:0]  gain_q;
  logic [aags_pkg::P1_W-1:0]    p1_q;
  logic [aags_pkg::P2_W-1:0]    p2_q;
  logic [aags_pkg::TOT_W-1:0]   tot_q;
  logic [aags_pkg::NUM_W-1:0]   num;
  logic                         eval_q;
  aags_pkg::aags_dir_e          dir_q;
  logic [aags_pkg::CNT_W-1:0]   cnt_new_q;
  logic [aags_pkg::PRE_W-1:0]   pre_gain_q;
  logic [aags_pkg::PRE_W-1:0]   pre_avg_q;
  logic [aags_pkg::PROD_W-1:0]  prod_gain_q;
  logic [aags_pkg::PROD_W-1:0]  prod_avg_q;

  // Evaluation stage signals.
  logic [aags_pkg::AVG_W-1:0]   avg_new;
  logic [aags_pkg::CNT_W-1:0]   tot_sat;
  logic [aags_pkg::RATE_W+2:0]  thr6;
  logic [aags_pkg::CNT_W-1:0]   thr4;
  logic                         eval_new;
  aags_pkg::aags_dir_e          dir_new;
  logic [aags_pkg::PRE_W-1:0]   gain_ext;
  logic [aags_pkg::PRE_W-1:0]   avg_ext;
  logic [aags_pkg::PRE_W-1:0]   pre_gain_new;
  logic [aags_pkg::PRE_W-1:0]   pre_avg_new;
  logic [aags_pkg::RECIP_W-1:0] recip;

  // Rounded numerator: avg*count + vol*samples + total/2.
  assign num = aags_pkg::NUM_W'(p1_q) + aags_pkg::NUM_W'(p2_q)
             + aags_pkg::NUM_W'(tot_q >> 1);

  aags_div #(
    .NUM_W (aags_pkg::NUM_W),
    .DEN_W (aags_pkg::TOT_W),
    .QUO_W (aags_pkg::QUO_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (tot_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    // With no history and an empty block the average stays as it was.
    avg_new  = (tot_q == '0) ? avg_q : div_quo[aags_pkg::AVG_W-1:0];
    tot_sat  = (tot_q > aags_pkg::TOT_W'(aags_pkg::COUNT_MAX))
               ? aags_pkg::COUNT_MAX : tot_q[aags_pkg::CNT_W-1:0];
    thr6     = {1'b0, rate_q, 2'b00} + {2'b00, rate_q, 1'b0};
    thr4     = aags_pkg::CNT_W'({rate_q, 2'b00});
    eval_new = tot_sat > aags_pkg::CNT_W'(thr6);

    dir_new = aags_pkg::DIR_NONE;
    if (eval_new) begin
      if ((avg_new < aags_pkg::TH_QUIET_HI) && (avg_new > aags_pkg::TH_QUIET_LO)) begin
        dir_new = aags_pkg::DIR_UP;
      end else if (avg_new > aags_pkg::TH_LOUD) begin
        dir_new = aags_pkg::DIR_DOWN;
      end else if ((avg_new > aags_pkg::TH_HYST_DOWN) && (gain_q > aags_pkg::UNITY_GAIN)) begin
        dir_new = aags_pkg::DIR_DOWN;
      end else if ((avg_new < aags_pkg::TH_HYST_UP) && (gain_q < aags_pkg::UNITY_GAIN)) begin
        dir_new = aags_pkg::DIR_UP;
      end
    end

    // Times 1.1 is (11x+5)/10 and over 1.1 is (10x+5)/11.
    gain_ext = aags_pkg::PRE_W'(gain_q);
    avg_ext  = aags_pkg::PRE_W'(avg_new);
    if (dir_new == aags_pkg::DIR_UP) begin
      pre_gain_new = (gain_ext << 3) + (gain_ext << 1) + gain_ext + aags_pkg::PRE_W'(5);
      pre_avg_new  = (avg_ext << 3) + (avg_ext << 1) + avg_ext + aags_pkg::PRE_W'(5);
    end else begin
      pre_gain_new = (gain_ext << 3) + (gain_ext << 1) + aags_pkg::PRE_W'(5);
      pre_avg_new  = (avg_ext << 3) + (avg_ext << 1) + aags_pkg::PRE_W'(5);
    end
  end

  assign recip = (dir_q == aags_pkg::DIR_UP) ? aags_pkg::RECIP_10 : aags_pkg::RECIP_11;

  always_ff @(posedge clk_i) begin
    case (state_q)
      aags_pkg::ST_IDLE: begin
        if (in_acc) begin
          addr_q <= chan_addr;
          vol_q  <= block_volume_i;
          smp_q  <= block_samples_i;
        end
      end
      aags_pkg::ST_LOAD: begin
        avg_q  <= entry_rd.volume;
        cnt_q  <= entry_rd.count;
        gain_q <= entry_rd.gain;
      end
      aags_pkg::ST_MUL: begin
        p1_q  <= aags_pkg::P1_W'(avg_q) * aags_pkg::P1_W'(cnt_q);
        p2_q  <= aags_pkg::P2_W'(vol_q) * aags_pkg::P2_W'(smp_q);
        tot_q <= aags_pkg::TOT_W'(cnt_q) + aags_pkg::TOT_W'(smp_q);
      end
      aags_pkg::ST_EVAL: begin
        avg_q      <= avg_new;
        eval_q     <= eval_new;
        dir_q      <= dir_new;
        cnt_new_q  <= eval_new ? thr4 : tot_sat;
        pre_gain_q <= pre_gain_new;
        pre_avg_q  <= pre_avg_new;
      end
      aags_pkg::ST_SCALE: begin
        prod_gain_q <= aags_pkg::PROD_W'(pre_gain_q) * aags_pkg::PROD_W'(recip);
        prod_avg_q  <= aags_pkg::PROD_W'(pre_avg_q) * aags_pkg::PROD_W'(recip);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result selection and output register
  // ---------------------------------------------------------------------------
  logic [aags_pkg::SCL_W-1:0]  gain_scl;
  logic [aags_pkg::SCL_W-1:0]  avg_scl;
  logic [aags_pkg::GAIN_W-1:0] gain_res;
  logic [aags_pkg::AVG_W-1:0]  avg_res;
  logic [aags_pkg::GAIN_W-1:0] out_gain;
  logic [aags_pkg::AVG_W-1:0]  out_avg;
  logic                        out_eval;
  logic                        out_chg;
  logic                        out_vld_q;
  logic [aags_pkg::GAIN_W-1:0] out_gain_q;
  logic [aags_pkg::AVG_W-1:0]  out_avg_q;
  logic                        out_eval_q;
  logic                        out_chg_q;

  assign gain_scl = prod_gain_q[aags_pkg::RECIP_SH +: aags_pkg::SCL_W];
  assign avg_scl  = prod_avg_q[aags_pkg::RECIP_SH +: aags_pkg::SCL_W];

  always_comb begin
    case (dir_q)
      aags_pkg::DIR_UP: begin
        gain_res = (gain_scl > aags_pkg::SCL_W'(aags_pkg::GAIN_MAX))
                   ? aags_pkg::GAIN_MAX : gain_scl[aags_pkg::GAIN_W-1:0];
        avg_res  = (avg_scl > aags_pkg::SCL_W'(aags_pkg::AVG_MAX))
                   ? aags_pkg::AVG_MAX : avg_scl[aags_pkg::AVG_W-1:0];
      end
      aags_pkg::DIR_DOWN: begin
        gain_res = gain_scl[aags_pkg::GAIN_W-1:0];
        avg_res  = avg_scl[aags_pkg::AVG_W-1:0];
      end
      default: begin
        gain_res = gain_q;
        avg_res  = avg_q;
      end
    endcase

    ram_wdata.gain   = gain_res;
    ram_wdata.count  = cnt_new_q;
    ram_wdata.volume = avg_res;

    case (op_q)
      aags_pkg::OP_UPDATE: begin
        out_gain = gain_res;
        out_avg  = avg_res;
        out_eval = eval_q;
        out_chg  = (dir_q != aags_pkg::DIR_NONE);
      end
      aags_pkg::OP_CLEAR: begin
        out_gain = aags_pkg::UNITY_GAIN;
        out_avg  = aags_pkg::UNITY_AVG;
        out_eval = 1'b0;
        out_chg  = 1'b0;
      end
      default: begin
        out_gain = '0;
        out_avg  = '0;
        out_eval = 1'b0;
        out_chg  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_gain_q <= out_gain;
      out_avg_q  <= out_avg;
      out_eval_q <= out_eval;
      out_chg_q  <= out_chg;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign gain_o             = out_gain_q;
  assign average_volume_o   = out_avg_q;
  assign window_evaluated_o = out_eval_q;
  assign gain_changed_o     = out_chg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aags_pkg::ST_DIV) |-> (div_busy || div_done))
    else $error("divider idle while waiting for a quotient");

  a_change_needs_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gain_changed_o) |-> window_evaluated_o)
    else $error("gain changed without window evaluation");

  a_update_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (op_q == aags_pkg::OP_UPDATE)) |=> vld_q[addr_q])
    else $error("updated channel entry not marked valid");

  a_clear_drops_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (op_q == aags_pkg::OP_CLEAR)) |=> !vld_q[addr_q])
    else $error("cleared channel entry still marked valid");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the per-channel automatic gain step core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH     = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE     = 60;

  typedef struct packed {
    logic                        cmd;
    logic [aags_pkg::CHAN_W-1:0] ch;
    logic [aags_pkg::BVOL_W-1:0] vol;
    logic [aags_pkg::BSMP_W-1:0] smp;
  } gain_req_t;

  typedef struct packed {
    logic [aags_pkg::GAIN_W-1:0] gain;
    logic [aags_pkg::AVG_W-1:0]  avg;
    logic                        evaluated;
    logic                        changed;
  } gain_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [aags_pkg::PADDR_W-1:0] paddr = '0;
  logic [aags_pkg::PDATA_W-1:0] pwdata = '0;
  logic [aags_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        command_i = aags_pkg::CMD_UPDATE;
  logic [aags_pkg::CHAN_W-1:0] channel_i = '0;
  logic [aags_pkg::BVOL_W-1:0] block_volume_i = '0;
  logic [aags_pkg::BSMP_W-1:0] block_samples_i = '0;

  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [aags_pkg::GAIN_W-1:0] gain_o;
  logic [aags_pkg::AVG_W-1:0]  average_volume_o;
  logic                        window_evaluated_o;
  logic                        gain_changed_o;

  audio_auto_gain_step_core #(
    .CHANNELS(NUM_CH)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .channel_i          (channel_i),
    .block_volume_i     (block_volume_i),
    .block_samples_i    (block_samples_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .gain_o             (gain_o),
    .average_volume_o   (average_volume_o),
    .window_evaluated_o (window_evaluated_o),
    .gain_changed_o     (gain_changed_o)
  );

  // Mirror of the per-channel gain state and the rate register.
  logic [aags_pkg::AVG_W-1:0]  ch_avg  [NUM_CH];
  logic [aags_pkg::CNT_W-1:0]  ch_cnt  [NUM_CH];
  logic [aags_pkg::GAIN_W-1:0] ch_gain [NUM_CH];
  logic [aags_pkg::RATE_W-1:0] rate_model = aags_pkg::RATE_RESET;

  gain_req_t agc_requests_todo[$];
  gain_res_t gain_results_due[$];

  bit req_fired = 1'b0;
  bit choke_ask = 1'b0;
  int err_count = 0;
  int cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] scale_up(input logic [63:0] x, input logic [63:0] lim);
    logic [63:0] r;
    r = (x * 11 + 5) / 10;
    return (r > lim) ? lim : r;
  endfunction

  function automatic logic [63:0] scale_down(input logic [63:0] x);
    return (x * 10 + 5) / 11;
  endfunction

  // Weighted average update, window check and rule evaluation for one request.
  function automatic gain_res_t apply_gain_step(input gain_req_t r);
    logic [63:0]         cnt;
    logic [63:0]         tot;
    logic [63:0]         avg;
    logic [63:0]         gn;
    aags_pkg::aags_dir_e dir;
    gain_res_t           res;
    res = '0;
    if (int'(r.ch) < NUM_CH) begin
      if (r.cmd == aags_pkg::CMD_CLEAR) begin
        ch_avg[r.ch]  = aags_pkg::UNITY_AVG;
        ch_cnt[r.ch]  = '0;
        ch_gain[r.ch] = aags_pkg::UNITY_GAIN;
      end else begin
        cnt = 64'(ch_cnt[r.ch]);
        tot = cnt + 64'(r.smp);
        avg = 64'(ch_avg[r.ch]);
        gn  = 64'(ch_gain[r.ch]);
        if (tot != 0) begin
          avg = (avg * cnt + 64'(r.vol) * 64'(r.smp) + tot / 2) / tot;
          if (avg > 64'(aags_pkg::AVG_MAX)) avg = 64'(aags_pkg::AVG_MAX);
        end
        if (tot > 64'(aags_pkg::COUNT_MAX)) tot = 64'(aags_pkg::COUNT_MAX);
        if (tot > 64'(rate_model) * 6) begin
          res.evaluated = 1'b1;
          dir = aags_pkg::DIR_NONE;
          if (avg < 64'(aags_pkg::TH_QUIET_HI) && avg > 64'(aags_pkg::TH_QUIET_LO))
            dir = aags_pkg::DIR_UP;
          else if (avg > 64'(aags_pkg::TH_LOUD))
            dir = aags_pkg::DIR_DOWN;
          else if (avg > 64'(aags_pkg::TH_HYST_DOWN) && gn > 64'(aags_pkg::UNITY_GAIN))
            dir = aags_pkg::DIR_DOWN;
          else if (avg < 64'(aags_pkg::TH_HYST_UP) && gn < 64'(aags_pkg::UNITY_GAIN))
            dir = aags_pkg::DIR_UP;
          case (dir)
            aags_pkg::DIR_UP: begin
              gn  = scale_up(gn, 64'(aags_pkg::GAIN_MAX));
              avg = scale_up(avg, 64'(aags_pkg::AVG_MAX));
              res.changed = 1'b1;
            end
            aags_pkg::DIR_DOWN: begin
              gn  = scale_down(gn);
              avg = scale_down(avg);
              res.changed = 1'b1;
            end
            default: ;
          endcase
          tot = 64'(rate_model) * 4;
        end
        ch_avg[r.ch]  = avg[aags_pkg::AVG_W-1:0];
        ch_cnt[r.ch]  = tot[aags_pkg::CNT_W-1:0];
        ch_gain[r.ch] = gn[aags_pkg::GAIN_W-1:0];
      end
      res.gain = ch_gain[r.ch];
      res.avg  = ch_avg[r.ch];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    err_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result check first, then prediction for a request taken at the same edge.
  always @(posedge clk_i) begin
    gain_res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (gain_results_due.size() == 0) begin
          report_mismatch("unexpected result, gain", 0, gain_o);
        end else begin
          want = gain_results_due.pop_front();
          if (gain_o !== want.gain) report_mismatch("gain", want.gain, gain_o);
          if (average_volume_o !== want.avg)
            report_mismatch("average_volume", want.avg, average_volume_o);
          if (window_evaluated_o !== want.evaluated)
            report_mismatch("window_evaluated", want.evaluated, window_evaluated_o);
          if (gain_changed_o !== want.changed)
            report_mismatch("gain_changed", want.changed, gain_changed_o);
        end
      end
      req_fired = in_valid_i && !in_stall_o;
      if (req_fired)
        gain_results_due.push_back(apply_gain_step(
          '{command_i, channel_i, block_volume_i, block_samples_i}));
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Request driver: holds each request until taken, then an optional gap.
  int send_gap = 0;
  int burst_left = 0;
  always @(negedge clk_i) begin
    gain_req_t nxt;
    int pick;
    if (rst_ni && (!in_valid_i || req_fired)) begin
      if (send_gap > 0 || agc_requests_todo.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        nxt = agc_requests_todo.pop_front();
        in_valid_i      <= 1'b1;
        command_i       <= nxt.cmd;
        channel_i       <= nxt.ch;
        block_volume_i  <= nxt.vol;
        block_samples_i <= nxt.smp;
        if (burst_left > 0) begin
          burst_left--;
          send_gap = 0;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 2) begin
            burst_left = $urandom_range(15, 60);
            send_gap = 0;
          end else if (pick < 55) begin
            send_gap = 0;
          end else if (pick < 90) begin
            send_gap = $urandom_range(1, 3);
          end else begin
            send_gap = $urandom_range(8, 40);
          end
        end
      end
    end
  end

  // Result-side backpressure, with one long hold-off on request.
  int stall_left = 0;
  int calm_left = 0;
  int choke_left = 0;
  bit choke_done = 1'b0;
  always @(negedge clk_i) begin
    int pick;
    if (rst_ni) begin
      if (choke_ask && !choke_done) begin
        choke_done = 1'b1;
        choke_left = 400;
      end
      if (choke_left > 0) begin
        choke_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          calm_left = $urandom_range(30, 150);
          out_stall_i <= 1'b0;
        end else if (pick < 60) begin
          out_stall_i <= 1'b0;
        end else if (pick < 95) begin
          stall_left = $urandom_range(0, 2);
          out_stall_i <= 1'b1;
        end else begin
          stall_left = $urandom_range(10, 60);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  task automatic offer(input logic cmd, input int ch, input int vol, input int smp);
    agc_requests_todo.push_back('{cmd, aags_pkg::CHAN_W'(ch), aags_pkg::BVOL_W'(vol),
                                  aags_pkg::BSMP_W'(smp)});
  endtask

  task automatic wait_idle();
    while (agc_requests_todo.size() != 0 || in_valid_i || gain_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic write_rate(input logic [aags_pkg::RATE_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= aags_pkg::ADDR_RATE;
    pwdata  <= aags_pkg::PDATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rate_model = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[aags_pkg::RATE_W-1:0] !== val) report_mismatch("rate read", val, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int pick_volume(input int level);
    case (level)
      0: return $urandom_range(0, 7);
      1: return $urandom_range(8, 654);
      2: return $urandom_range(655, 13107);
      3: return $urandom_range(3278, 30000);
      4: return $urandom_range(16385, 65536);
      default: begin
        case ($urandom_range(0, 8))
          0: return 0;
          1: return 7;
          2: return 8;
          3: return 654;
          4: return 655;
          5: return 16384;
          6: return 16385;
          7: return 65535;
          default: return 65536;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_samples();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return 65535;
    if (pick < 6) return $urandom_range(1, 999);
    return $urandom_range(1000, 65535);
  endfunction

  // Mostly runs of updates to one channel at a steady level, plus some noise.
  task automatic queue_random(input int n_items, input int ch_top);
    int sent;
    int run;
    int level;
    int ch;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        offer(($urandom_range(0, 3) == 0) ? aags_pkg::CMD_CLEAR : aags_pkg::CMD_UPDATE,
              $urandom_range(0, 7), $urandom_range(0, 65536), $urandom_range(0, 65535));
        sent++;
      end else begin
        ch = $urandom_range(0, ch_top);
        level = $urandom_range(0, 5);
        run = $urandom_range(3, 12);
        repeat (run) begin
          offer(aags_pkg::CMD_UPDATE, ch, pick_volume(level), pick_samples());
          sent++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      ch_avg[i]  = aags_pkg::UNITY_AVG;
      ch_cnt[i]  = '0;
      ch_gain[i] = aags_pkg::UNITY_GAIN;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset rate: empty history, full-scale block, clear, a slow quiet raise.
    offer(aags_pkg::CMD_UPDATE, 0, 0, 0);
    offer(aags_pkg::CMD_UPDATE, 1, 65536, 65535);
    offer(aags_pkg::CMD_UPDATE, 2, 1, 1);
    offer(aags_pkg::CMD_CLEAR, 1, 65536, 65535);
    repeat (5) offer(aags_pkg::CMD_UPDATE, 3, 300, 65535);
    wait_idle();

    // Short window: each rule in turn, then the strict threshold edges.
    write_rate(100);
    offer(aags_pkg::CMD_UPDATE, 4, 300, 1000);
    offer(aags_pkg::CMD_UPDATE, 4, 3000, 1000);
    offer(aags_pkg::CMD_UPDATE, 4, 9000, 1000);
    offer(aags_pkg::CMD_UPDATE, 5, 40000, 1000);
    offer(aags_pkg::CMD_UPDATE, 5, 8000, 60000);
    offer(aags_pkg::CMD_UPDATE, 6, 7, 1000);
    offer(aags_pkg::CMD_UPDATE, 7, 655, 1000);
    offer(aags_pkg::CMD_UPDATE, 2, 16385, 65535);
    offer(aags_pkg::CMD_UPDATE, 0, 0, 65535);
    wait_idle();

    // A zero rate evaluates on any nonzero count but not on an empty one.
    write_rate(0);
    offer(aags_pkg::CMD_UPDATE, 1, 100, 1);
    offer(aags_pkg::CMD_CLEAR, 3, 0, 0);
    offer(aags_pkg::CMD_UPDATE, 3, 65536, 0);
    wait_idle();

    write_rate(48000);
    queue_random(150, 7);
    choke_ask = 1'b1;
    wait_idle();
    queue_random(150, 7);
    wait_idle();

    write_rate(1);
    queue_random(200, 7);
    wait_idle();

    write_rate(44100);
    queue_random(250, 7);
    wait_idle();

    write_rate(22'h3F_FFFF);
    queue_random(150, 0);
    wait_idle();

    write_rate(aags_pkg::RATE_W'($urandom_range(2, 5000)));
    queue_random(200, 7);
    wait_idle();

    write_rate(0);
    queue_random(150, 7);
    wait_idle();

    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0 && gain_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
